### sv/tfgc_pkg.sv
// ----------------------------------------------------------------------------
// tfgc_pkg
// Shared types and constants of the two-finger gesture classifier: gesture
// codes, opcodes, register indexes, reset values and the item, state and
// configuration records passed between modules.
// ----------------------------------------------------------------------------
package tfgc_pkg;

    typedef enum logic [1:0] {
        KIND_NULL   = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_SCROLL = 2'd2
    } t_kind;

    localparam logic OP_RESTART  = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [3:0] COUNT_NONE = 4'd0;
    localparam logic [3:0] COUNT_ONE  = 4'd1;
    localparam logic [3:0] COUNT_TWO  = 4'd2;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    typedef enum logic [2:0] {
        REG_BOTTOM_EDGE        = 3'd0,
        REG_BOTTOM_ZONE_HEIGHT = 3'd1,
        REG_PRESSURE_DIFF      = 3'd2,
        REG_CLOSE_DISTANCE     = 3'd3,
        REG_SCROLL_DISTANCE    = 3'd4,
        REG_STATIONARY_LIMIT   = 3'd5,
        REG_EVAL_WINDOW        = 3'd6,
        REG_MANY_FINGER_SCROLL = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] bottom_edge;
        logic [11:0] bottom_zone_height;
        logic [7:0]  pressure_diff_limit;
        logic [11:0] close_distance;
        logic [11:0] scroll_distance;
        logic [11:0] stationary_limit;
        logic [15:0] evaluation_window_ms;
        logic        many_finger_scroll;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bottom_edge:          15'd1600,
        bottom_zone_height:   12'd160,
        pressure_diff_limit:  8'd17,
        close_distance:       12'd640,
        scroll_distance:      12'd32,
        stationary_limit:     12'd16,
        evaluation_window_ms: 16'd200,
        many_finger_scroll:   1'b0
    };

    typedef struct packed {
        logic               opcode;
        logic [31:0]        time_ms;
        logic [3:0]         gesturing_count;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic [7:0]         first_pressure;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic [7:0]         second_pressure;
    } t_item;

    typedef struct packed {
        logic [31:0]        change_time;
        logic signed [15:0] start_first_x;
        logic signed [15:0] start_first_y;
        logic signed [15:0] start_second_x;
        logic signed [15:0] start_second_y;
        t_kind              kind;
    } t_track;

endpackage

### sv/tfgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfgc_cfg_regs
// Configuration register file behind a simple APB slave. Writes complete in
// the access phase; reads return the zero-extended register value.
// ----------------------------------------------------------------------------
module tfgc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfgc_pkg::AddrWidth-1:0]  paddr,
    input  logic [tfgc_pkg::DataWidth-1:0]  pwdata,
    output logic [tfgc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    output tfgc_pkg::t_cfg                  o_cfg
);

    tfgc_pkg::t_cfg     r_cfg;
    tfgc_pkg::t_cfg     n_cfg;
    tfgc_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = tfgc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                tfgc_pkg::REG_BOTTOM_EDGE:        n_cfg.bottom_edge = pwdata[14:0];
                tfgc_pkg::REG_BOTTOM_ZONE_HEIGHT: n_cfg.bottom_zone_height = pwdata[11:0];
                tfgc_pkg::REG_PRESSURE_DIFF:      n_cfg.pressure_diff_limit = pwdata[7:0];
                tfgc_pkg::REG_CLOSE_DISTANCE:     n_cfg.close_distance = pwdata[11:0];
                tfgc_pkg::REG_SCROLL_DISTANCE:    n_cfg.scroll_distance = pwdata[11:0];
                tfgc_pkg::REG_STATIONARY_LIMIT:   n_cfg.stationary_limit = pwdata[11:0];
                tfgc_pkg::REG_EVAL_WINDOW:        n_cfg.evaluation_window_ms = pwdata[15:0];
                tfgc_pkg::REG_MANY_FINGER_SCROLL: n_cfg.many_finger_scroll = pwdata[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tfgc_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            tfgc_pkg::REG_BOTTOM_EDGE:        prdata = {17'd0, r_cfg.bottom_edge};
            tfgc_pkg::REG_BOTTOM_ZONE_HEIGHT: prdata = {20'd0, r_cfg.bottom_zone_height};
            tfgc_pkg::REG_PRESSURE_DIFF:      prdata = {24'd0, r_cfg.pressure_diff_limit};
            tfgc_pkg::REG_CLOSE_DISTANCE:     prdata = {20'd0, r_cfg.close_distance};
            tfgc_pkg::REG_SCROLL_DISTANCE:    prdata = {20'd0, r_cfg.scroll_distance};
            tfgc_pkg::REG_STATIONARY_LIMIT:   prdata = {20'd0, r_cfg.stationary_limit};
            tfgc_pkg::REG_EVAL_WINDOW:        prdata = {16'd0, r_cfg.evaluation_window_ms};
            tfgc_pkg::REG_MANY_FINGER_SCROLL: prdata = {31'd0, r_cfg.many_finger_scroll};
            default: prdata = '0;
        endcase
    end

endmodule

### sv/tfgc_judge.sv
// ----------------------------------------------------------------------------
// tfgc_judge
// Combinational classifier. From one registered item, the tracked gesture
// state and the configuration it forms the next gesture kind, using the
// closeness test and the dominant-axis travel test for two fingers.
// ----------------------------------------------------------------------------
module tfgc_judge (
    input  tfgc_pkg::t_item  i_item,
    input  tfgc_pkg::t_track i_track,
    input  tfgc_pkg::t_cfg   i_cfg,
    output tfgc_pkg::t_kind  o_kind
);

    function automatic logic [16:0] mag17(input logic signed [16:0] a);
        logic [16:0] r;
        r = a[16] ? 17'(-a) : 17'(a);
        return r;
    endfunction

    function automatic logic [16:0] sub17(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
        logic [16:0] r;
        r = {a[15], a} - {b[15], b};
        return r;
    endfunction

    logic [8:0]         w_pdiff;
    logic [7:0]         w_pmag;
    logic [15:0]        w_xd;
    logic [15:0]        w_yd;
    logic [31:0]        w_xsq;
    logic [31:0]        w_ysq;
    logic [32:0]        w_dsq;
    logic [23:0]        w_lim_sq;
    logic signed [15:0] w_thresh;
    logic               w_thumb;
    logic               w_close;
    logic signed [16:0] w_dx1;
    logic signed [16:0] w_dy1;
    logic signed [16:0] w_dx2;
    logic signed [16:0] w_dy2;
    logic signed [16:0] w_ldx;
    logic signed [16:0] w_sdx;
    logic signed [16:0] w_ldy;
    logic signed [16:0] w_sdy;
    logic signed [16:0] w_large;
    logic signed [16:0] w_small;
    logic signed [16:0] w_small_z;
    logic               w_same_dir;
    tfgc_pkg::t_kind    w_travel;
    logic [31:0]        w_elapsed;
    logic               w_in_window;

    // Closeness of the two fingers.
    assign w_pdiff  = {1'b0, i_item.first_pressure} - {1'b0, i_item.second_pressure};
    assign w_pmag   = w_pdiff[8] ? 8'(-w_pdiff) : w_pdiff[7:0];
    assign w_xd     = 16'(mag17(sub17(i_item.first_x, i_item.second_x)));
    assign w_yd     = 16'(mag17(sub17(i_item.first_y, i_item.second_y)));
    assign w_xsq    = w_xd * w_xd;
    assign w_ysq    = w_yd * w_yd;
    assign w_dsq    = {1'b0, w_xsq} + {1'b0, w_ysq};
    assign w_lim_sq = i_cfg.close_distance * i_cfg.close_distance;
    assign w_thresh = $signed({1'b0, i_cfg.bottom_edge} - {4'd0, i_cfg.bottom_zone_height});
    assign w_thumb  = (i_item.first_y > w_thresh) || (i_item.second_y > w_thresh);
    assign w_close  = (w_pmag <= i_cfg.pressure_diff_limit)
                   && (w_dsq <= {9'd0, w_lim_sq})
                   && !((w_xd < w_yd) && w_thumb);

    // Travel from the start positions along the dominant axis.
    assign w_dx1 = $signed(sub17(i_item.first_x, i_track.start_first_x));
    assign w_dy1 = $signed(sub17(i_item.first_y, i_track.start_first_y));
    assign w_dx2 = $signed(sub17(i_item.second_x, i_track.start_second_x));
    assign w_dy2 = $signed(sub17(i_item.second_y, i_track.start_second_y));
    assign w_ldx = (mag17(w_dx1) > mag17(w_dx2)) ? w_dx1 : w_dx2;
    assign w_sdx = (mag17(w_dx1) < mag17(w_dx2)) ? w_dx1 : w_dx2;
    assign w_ldy = (mag17(w_dy1) > mag17(w_dy2)) ? w_dy1 : w_dy2;
    assign w_sdy = (mag17(w_dy1) < mag17(w_dy2)) ? w_dy1 : w_dy2;

    always_comb begin
        if (mag17(w_ldx) > mag17(w_ldy)) begin
            w_large = w_ldx;
            w_small = w_sdx;
        end else begin
            w_large = w_ldy;
            w_small = w_sdy;
        end
    end

    assign w_small_z  = (mag17(w_small) < {5'd0, i_cfg.stationary_limit}) ? '0 : w_small;
    assign w_same_dir = (!w_large[16] && !w_small_z[16])
                     || ((w_large[16] || (w_large == '0))
                         && (w_small_z[16] || (w_small_z == '0)));

    always_comb begin
        if (mag17(w_large) < {5'd0, i_cfg.scroll_distance}) begin
            w_travel = tfgc_pkg::KIND_NULL;
        end else if (w_same_dir) begin
            w_travel = tfgc_pkg::KIND_SCROLL;
        end else begin
            w_travel = tfgc_pkg::KIND_NULL;
        end
    end

    assign w_elapsed   = i_item.time_ms - i_track.change_time;
    assign w_in_window = w_elapsed < {16'd0, i_cfg.evaluation_window_ms};

    always_comb begin
        o_kind = i_track.kind;
        if (i_item.opcode == tfgc_pkg::OP_CLASSIFY) begin
            if (i_item.gesturing_count == tfgc_pkg::COUNT_NONE) begin
                o_kind = tfgc_pkg::KIND_NULL;
            end else if (i_item.gesturing_count == tfgc_pkg::COUNT_ONE) begin
                o_kind = tfgc_pkg::KIND_MOVE;
            end else if (i_item.gesturing_count == tfgc_pkg::COUNT_TWO) begin
                if (w_in_window || (i_track.kind == tfgc_pkg::KIND_NULL)) begin
                    o_kind = w_close ? w_travel : tfgc_pkg::KIND_MOVE;
                end
            end else if (i_cfg.many_finger_scroll) begin
                o_kind = tfgc_pkg::KIND_SCROLL;
            end
        end
    end

endmodule

### sv/two_finger_gesture_classifier.sv
// ----------------------------------------------------------------------------
// two_finger_gesture_classifier
// Touchpad gesture classifier: restart items record the finger start state,
// frame items update and report the current gesture kind.
// ----------------------------------------------------------------------------
// Usage: items enter on the input channel (i_in_valid / o_in_ready) and one
// result per item leaves on the output channel (o_out_valid / i_out_ready).
// Restart items (opcode 0) store the change time and start positions and
// report the unchanged gesture kind; frame items (opcode 1) classify.
// An accepted item is held in an input register; once the output side is
// free, the classifier logic updates the tracked state and loads the result
// register. One item is accepted per cycle while the output side keeps up;
// the single classify stage sets this rate. When the receiver stalls, the
// result register holds its item and the input register still takes one
// more item, after which o_in_ready drops. Reset clears both valid flags,
// the tracked state (gesture kind null) and loads the register defaults.
// The user must write the APB port only while idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module two_finger_gesture_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfgc_pkg::AddrWidth-1:0]  paddr,
    input  logic [tfgc_pkg::DataWidth-1:0]  pwdata,
    output logic [tfgc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [31:0]                     i_time_ms,
    input  logic [3:0]                      i_gesturing_count,
    input  logic signed [15:0]              i_first_x,
    input  logic signed [15:0]              i_first_y,
    input  logic [7:0]                      i_first_pressure,
    input  logic signed [15:0]              i_second_x,
    input  logic signed [15:0]              i_second_y,
    input  logic [7:0]                      i_second_pressure,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_gesture_kind
);

    tfgc_pkg::t_cfg   w_cfg;
    tfgc_pkg::t_item  r_item;
    logic             r_in_vld;
    tfgc_pkg::t_track r_track;
    tfgc_pkg::t_track n_track;
    tfgc_pkg::t_kind  w_kind;
    tfgc_pkg::t_kind  r_kind;
    logic             r_out_vld;
    logic             w_out_free;
    logic             w_step;
    logic             w_take;

    tfgc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tfgc_judge u_judge (
        .i_item  (r_item),
        .i_track (r_track),
        .i_cfg   (w_cfg),
        .o_kind  (w_kind)
    );

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_step     = r_in_vld && w_out_free;
    assign o_in_ready = !r_in_vld || w_out_free;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_track = r_track;
        if (w_step) begin
            n_track.kind = w_kind;
            if (r_item.opcode == tfgc_pkg::OP_RESTART) begin
                n_track.change_time    = r_item.time_ms;
                n_track.start_first_x  = r_item.first_x;
                n_track.start_first_y  = r_item.first_y;
                n_track.start_second_x = r_item.second_x;
                n_track.start_second_y = r_item.second_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_track   <= '0;
        end else begin
            r_track <= n_track;
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_step) begin
                r_in_vld <= 1'b0;
            end
            if (w_step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.opcode          <= i_opcode;
            r_item.time_ms         <= i_time_ms;
            r_item.gesturing_count <= i_gesturing_count;
            r_item.first_x         <= i_first_x;
            r_item.first_y         <= i_first_y;
            r_item.first_pressure  <= i_first_pressure;
            r_item.second_x        <= i_second_x;
            r_item.second_y        <= i_second_y;
            r_item.second_pressure <= i_second_pressure;
        end
        if (w_step) begin
            r_kind <= w_kind;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_gesture_kind = r_kind;

endmodule
